>>> rtl/core/gem3_pkg.sv
//------------------------------------------------------------------------------
// gem3_pkg
// Shared types and constants of the 3x3 gradient edge magnitude unit.
//------------------------------------------------------------------------------
package gem3_pkg;

    localparam int unsigned MAX_WIDTH_DEF = 256;
    localparam int unsigned HEIGHT_LIMIT  = 4096;
    localparam int unsigned PIX_W  = 8;
    localparam int unsigned ROW_W  = 12;
    localparam int unsigned COL_W  = 8;
    localparam int unsigned CFG_W  = 13;
    localparam int unsigned CIDX_W = 2;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_KERNEL = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        K_ROBERTS = 2'd0,
        K_PREWITT = 2'd1,
        K_SOBEL   = 2'd2
    } t_kernel;

    // One queued job: up to three results caused by one pixel.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             em_first;   // (r-1, 0) border
        logic             em_mid;     // (r-1, c-1)
        logic             em_mid_calc;
        logic             em_right;   // (r-1, W-1) border
        logic             em_bottom;  // (H-1, c) border
        logic [COL_W-1:0] wlast;      // W-1
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
        logic [PIX_W-1:0] w0, w1, w2, w3, w4, w5;
        logic [1:0]       kmode;
    } t_job;

endpackage

>>> rtl/core/gem3_front.sv
//------------------------------------------------------------------------------
// gem3_front
// Accepts pixels, keeps line buffers, window and raster counters, and builds
// one job per pixel.
//------------------------------------------------------------------------------
module gem3_front #(
    parameter int unsigned MAX_WIDTH = gem3_pkg::MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [gem3_pkg::CIDX_W-1:0]  i_cfg_idx,
    input  logic [gem3_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [gem3_pkg::PIX_W-1:0]   i_pixel,
    output logic                         o_job_valid,
    input  logic                         i_job_stall,
    output gem3_pkg::t_job               o_job
);
    import gem3_pkg::*;

    localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned CW = $clog2(MAX_WIDTH + 1);

    logic [8:0]        r_width;
    logic [12:0]       r_height;
    logic [1:0]        r_kmode;
    logic [CW-1:0]     r_col;
    logic [ROW_W-1:0]  r_row;
    logic [PIX_W-1:0]  r_win [6];
    logic [PIX_W-1:0]  r_older [MAX_WIDTH];
    logic [PIX_W-1:0]  r_newer [MAX_WIDTH];

    // stage 1: pixel accepted, line buffer read in flight
    logic              r_s1_v;
    logic [PIX_W-1:0]  r_s1_pix;
    logic [CW-1:0]     r_s1_col;
    logic [ROW_W-1:0]  r_s1_row;
    logic [PIX_W-1:0]  r_top, r_mid;
    logic [CW-1:0]     r_s1_w;
    logic [ROW_W-1:0]  r_s1_hm1;

    logic [CW-1:0]     w_eff;
    logic [ROW_W:0]    h_eff;
    logic              acc, adv;
    logic [PIX_W-1:0]  top_f, mid_f;

    always_comb begin
        if (r_width < 9'd3) begin
            w_eff = CW'(3);
        end else if ({4'd0, r_width} > 13'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(r_width);
        end
        if (r_height < 13'd3) begin
            h_eff = (ROW_W+1)'(3);
        end else if (r_height > 13'(HEIGHT_LIMIT)) begin
            h_eff = (ROW_W+1)'(HEIGHT_LIMIT);
        end else begin
            h_eff = (ROW_W+1)'(r_height);
        end
    end

    assign adv     = !(o_job_valid && i_job_stall);
    assign o_stall = !adv;
    assign acc     = i_valid && adv;

    assign top_f = r_top;
    assign mid_f = r_mid;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_top <= r_older[r_col[AW-1:0]];
            r_mid <= r_newer[r_col[AW-1:0]];
        end
        if (r_s1_v && adv) begin
            r_older[r_s1_col[AW-1:0]] <= mid_f;
            r_newer[r_s1_col[AW-1:0]] <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_pix <= i_pixel;
            r_s1_col <= r_col;
            r_s1_row <= r_row;
            r_s1_w   <= w_eff;
            r_s1_hm1 <= ROW_W'(h_eff - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd256;
            r_height <= 13'd256;
            r_kmode  <= K_SOBEL;
            r_col    <= '0;
            r_row    <= '0;
            r_s1_v   <= 1'b0;
            for (int k = 0; k < 6; k++) r_win[k] <= '0;
        end else begin
            if (adv) begin
                r_s1_v <= acc;
            end
            if (r_s1_v && adv) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= top_f;
                r_win[4] <= mid_f;
                r_win[5] <= r_s1_pix;
            end
            if (acc) begin
                if (r_col + 1'b1 >= w_eff) begin
                    r_col <= '0;
                    r_row <= ({1'b0, r_row} + 1'b1 >= h_eff) ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_WIDTH: begin
                        r_width <= i_cfg_data[8:0];
                        r_col   <= '0;
                        r_row   <= '0;
                        for (int k = 0; k < 6; k++) r_win[k] <= '0;
                    end
                    CFG_HEIGHT: begin
                        r_height <= i_cfg_data;
                        r_col    <= '0;
                        r_row    <= '0;
                        for (int k = 0; k < 6; k++) r_win[k] <= '0;
                    end
                    CFG_KERNEL: r_kmode <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    logic [COL_W-1:0] c8;
    assign c8 = COL_W'(r_s1_col);

    always_comb begin
        o_job_valid      = r_s1_v;
        o_job            = '0;
        o_job.row        = r_s1_row - 1'b1;
        o_job.col        = c8;
        o_job.em_first   = (r_s1_row != '0) && (r_s1_col == '0);
        o_job.em_mid     = (r_s1_row != '0) && (r_s1_col >= CW'(2));
        o_job.em_mid_calc = (r_s1_row >= ROW_W'(2));
        o_job.em_right   = (r_s1_row != '0) && (r_s1_col == r_s1_w - 1'b1);
        o_job.em_bottom  = (r_s1_row == r_s1_hm1);
        o_job.wlast      = COL_W'(r_s1_w - 1'b1);
        o_job.top        = top_f;
        o_job.mid        = mid_f;
        o_job.bot        = r_s1_pix;
        o_job.w0 = r_win[0]; o_job.w1 = r_win[1]; o_job.w2 = r_win[2];
        o_job.w3 = r_win[3]; o_job.w4 = r_win[4]; o_job.w5 = r_win[5];
        o_job.kmode      = r_kmode;
    end

endmodule

>>> rtl/core/gem3_queue.sv
//------------------------------------------------------------------------------
// gem3_queue
// Two-entry job queue between front and back.
//------------------------------------------------------------------------------
module gem3_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  gem3_pkg::t_job  i_job,
    output logic            o_valid,
    input  logic            i_stall,
    output gem3_pkg::t_job  o_job
);
    import gem3_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !pop) else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !push) else $error("push into full queue");

endmodule

>>> rtl/core/gem3_back.sv
//------------------------------------------------------------------------------
// gem3_back
// Computes gradients and magnitude for a job and emits its results one by one.
//------------------------------------------------------------------------------
module gem3_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  gem3_pkg::t_job               i_job,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [gem3_pkg::ROW_W-1:0]   o_out_row,
    output logic [gem3_pkg::COL_W-1:0]   o_out_col,
    output logic [gem3_pkg::PIX_W-1:0]   o_magnitude,
    output logic                         o_last
);
    import gem3_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE, B_GRAD, B_SQ, B_ROOT, B_EMIT
    } t_bstate;

    t_bstate        r_st, n_st;
    t_job           r_job;
    logic signed [11:0] r_gx, r_gy;
    logic [22:0]    r_sum;
    logic [7:0]     r_root;
    logic [3:0]     r_bit;
    logic [3:0]     r_pend;     // first, mid, right, bottom
    logic           r_ov;
    logic [PIX_W-1:0] r_mag;

    logic signed [11:0] a00, a10, a20, a01, a11, a21, a02, a12, a22, gx, gy;
    logic [7:0]     t;
    logic [15:0]    tsq;
    logic [1:0]     sel;
    logic [3:0]     rest;

    assign a00 = 12'(r_job.w0); assign a10 = 12'(r_job.w1); assign a20 = 12'(r_job.w2);
    assign a01 = 12'(r_job.w3); assign a11 = 12'(r_job.w4); assign a21 = 12'(r_job.w5);
    assign a02 = 12'(r_job.top); assign a12 = 12'(r_job.mid); assign a22 = 12'(r_job.bot);

    always_comb begin
        case (t_kernel'(r_job.kmode))
            K_ROBERTS: begin
                gx = a11 - a22;
                gy = a12 - a21;
            end
            K_PREWITT: begin
                gx = (a02 + a12 + a22) - (a00 + a10 + a20);
                gy = (a20 + a21 + a22) - (a00 + a01 + a02);
            end
            default: begin
                gx = (a02 + (a12 <<< 1) + a22) - (a00 + (a10 <<< 1) + a20);
                gy = (a20 + (a21 <<< 1) + a22) - (a00 + (a01 <<< 1) + a02);
            end
        endcase
    end

    assign t   = r_root | (8'd1 << r_bit[2:0]);
    assign tsq = 16'(t) * 16'(t);

    // pick first pending result
    always_comb begin
        if (r_pend[0])      sel = 2'd0;
        else if (r_pend[1]) sel = 2'd1;
        else if (r_pend[2]) sel = 2'd2;
        else                sel = 2'd3;
        rest = r_pend & ~(4'd1 << sel);
    end

    assign o_valid = (r_st == B_EMIT);
    assign o_last  = (rest == 4'd0);
    assign o_stall = (r_st != B_IDLE);
    always_comb begin
        case (sel)
            2'd0: begin
                o_out_row = r_job.row; o_out_col = '0; o_magnitude = r_job.mid;
            end
            2'd1: begin
                o_out_row = r_job.row; o_out_col = r_job.col - 1'b1; o_magnitude = r_mag;
            end
            2'd2: begin
                o_out_row = r_job.row; o_out_col = r_job.wlast; o_magnitude = r_job.mid;
            end
            default: begin
                o_out_row = r_job.row + 1'b1; o_out_col = r_job.col;
                o_magnitude = r_job.bot;
            end
        endcase
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            B_IDLE: if (i_valid) n_st = B_GRAD;
            B_GRAD: begin
                if (r_pend == 4'd0)                     n_st = B_IDLE;
                else if (r_pend[1] && r_job.em_mid_calc) n_st = B_SQ;
                else                                     n_st = B_EMIT;
            end
            B_SQ:   n_st = B_ROOT;
            B_ROOT: if (r_bit == 4'd0 || r_ov) n_st = B_EMIT;
            B_EMIT: if (!i_stall && rest == 4'd0) n_st = B_IDLE;
            default: n_st = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= B_IDLE;
            r_pend <= '0;
        end else begin
            r_st <= n_st;
            case (r_st)
                B_IDLE: if (i_valid) begin
                    r_pend <= {i_job.em_bottom, i_job.em_right, i_job.em_mid, i_job.em_first};
                end
                B_EMIT: if (!i_stall) r_pend <= rest;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            B_IDLE: if (i_valid) r_job <= i_job;
            B_GRAD: begin
                r_gx  <= gx;
                r_gy  <= gy;
                r_mag <= r_job.w4;
            end
            B_SQ: begin
                r_sum  <= 23'(r_gx * r_gx) + 23'(r_gy * r_gy);
                r_root <= '0;
                r_bit  <= 4'd7;
                r_ov   <= 1'b0;
            end
            B_ROOT: begin
                if (r_bit == 4'd7 && r_sum >= 23'd65536) begin
                    r_ov  <= 1'b1;
                    r_mag <= 8'd255;
                end else begin
                    if (23'(tsq) <= r_sum) begin
                        r_root <= t;
                        if (r_bit == 4'd0) r_mag <= t;
                    end else if (r_bit == 4'd0) begin
                        r_mag <= r_root;
                    end
                    r_bit <= r_bit - 1'b1;
                end
            end
            default: ;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_pend != 4'd0)) else $error("emit with nothing pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(r_pend))
        else $error("stalled result lost");

endmodule

>>> rtl/core/gradient_edge_magnitude_3x3_unit.sv
//------------------------------------------------------------------------------
// gradient_edge_magnitude_3x3_unit
// 3x3 Roberts/Prewitt/Sobel edge magnitude on a raster pixel stream.
//------------------------------------------------------------------------------
// Pixels enter in raster order; a front stage reads the two line buffers and
// forms a job per pixel, a two-entry queue hands jobs to a back stage that
// emits up to three results. A pixel without results passes the back
// stage's idle and gradient states only, border-only pixels then emit their
// results one by one, and interior pixels add the squaring and an
// eight-step restoring square root: all share one sequencer.
module gradient_edge_magnitude_3x3_unit #(
    parameter int unsigned MAX_WIDTH = gem3_pkg::MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [gem3_pkg::CIDX_W-1:0]  i_cfg_idx,
    input  logic [gem3_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [gem3_pkg::PIX_W-1:0]   i_pixel,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [gem3_pkg::ROW_W-1:0]   o_out_row,
    output logic [gem3_pkg::COL_W-1:0]   o_out_col,
    output logic [gem3_pkg::PIX_W-1:0]   o_magnitude,
    output logic                         o_last
);
    import gem3_pkg::*;

    t_job f_job, q_job;
    logic f_v, f_st, q_v, q_st;

    gem3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .o_stall, .i_pixel,
        .o_job_valid(f_v), .i_job_stall(f_st), .o_job(f_job)
    );

    gem3_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_v), .o_stall(f_st), .i_job(f_job),
        .o_valid(q_v), .i_stall(q_st), .o_job(q_job)
    );

    gem3_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_v), .o_stall(q_st), .i_job(q_job),
        .o_valid, .i_stall, .o_out_row, .o_out_col, .o_magnitude, .o_last
    );

endmodule

>>> test/gem3_checker.sv
//------------------------------------------------------------------------------
// gem3_checker
// Watches the pixel and result channels of the edge magnitude unit, predicts
// each result from its own copy of line buffers, window and geometry, and
// compares every result transaction field by field in order.
//------------------------------------------------------------------------------
module gem3_checker
    import gem3_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_valid,
    input  logic              i_in_stall,
    input  logic [PIX_W-1:0]  i_pixel,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [ROW_W-1:0]  i_out_row,
    input  logic [COL_W-1:0]  i_out_col,
    input  logic [PIX_W-1:0]  i_magnitude,
    input  logic              i_last,
    output int                o_errors,
    output int                o_pending
);

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] mag;
        logic             last;
    } t_edge_res;

    t_edge_res        exp_q[$];
    logic [PIX_W-1:0] row_m2[MAX_WIDTH_DEF];
    logic [PIX_W-1:0] row_m1[MAX_WIDTH_DEF];
    logic [PIX_W-1:0] win[6];
    logic [8:0]       geo_w;
    logic [12:0]      geo_h;
    logic [1:0]       kmode;
    int unsigned      cur_row, cur_col;

    assign o_pending = exp_q.size();

    function automatic logic [PIX_W-1:0] edge_mag(int a[3][3], logic [1:0] m);
        int gx, gy, s, r, t;
        if (m == K_ROBERTS) begin
            gx = a[1][1] - a[2][2];
            gy = a[1][2] - a[2][1];
        end else if (m == K_PREWITT) begin
            gx = (a[0][2] + a[1][2] + a[2][2]) - (a[0][0] + a[1][0] + a[2][0]);
            gy = (a[2][0] + a[2][1] + a[2][2]) - (a[0][0] + a[0][1] + a[0][2]);
        end else begin
            gx = (a[0][2] + 2*a[1][2] + a[2][2]) - (a[0][0] + 2*a[1][0] + a[2][0]);
            gy = (a[2][0] + 2*a[2][1] + a[2][2]) - (a[0][0] + 2*a[0][1] + a[0][2]);
        end
        s = gx*gx + gy*gy;
        if (s >= 65536) return 8'hFF;
        r = 0;
        for (int b = 128; b != 0; b = b >> 1) begin
            t = r | b;
            if (t*t <= s) r = t;
        end
        return r[7:0];
    endfunction

    task automatic predict_pixel(logic [PIX_W-1:0] px);
        int unsigned w, h, r, c;
        logic [PIX_W-1:0] top, mid;
        t_edge_res res[$];
        int a[3][3];
        w = geo_w;
        h = geo_h;
        if (w < 3) w = 3;
        if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
        if (h < 3) h = 3;
        if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
        if (cur_col >= w) cur_col = 0;
        if (cur_row >= h) cur_row = 0;
        r = cur_row;
        c = cur_col;
        top = row_m2[c];
        mid = row_m1[c];
        if (r >= 1) begin
            if (c == 0) res.push_back('{ROW_W'(r - 1), '0, mid, 1'b0});
            if (c >= 2) begin
                if (r >= 2) begin
                    a[0][0] = win[0]; a[1][0] = win[1]; a[2][0] = win[2];
                    a[0][1] = win[3]; a[1][1] = win[4]; a[2][1] = win[5];
                    a[0][2] = top;    a[1][2] = mid;    a[2][2] = px;
                    res.push_back('{ROW_W'(r - 1), COL_W'(c - 1), edge_mag(a, kmode), 1'b0});
                end else begin
                    res.push_back('{ROW_W'(r - 1), COL_W'(c - 1), win[4], 1'b0});
                end
            end
            if (c == w-1) res.push_back('{ROW_W'(r - 1), COL_W'(w - 1), mid, 1'b0});
        end
        if (r == h-1) res.push_back('{ROW_W'(h - 1), COL_W'(c), px, 1'b0});
        if (res.size() > 0) res[res.size()-1].last = 1'b1;
        foreach (res[i]) exp_q.push_back(res[i]);
        win[0] = win[3]; win[1] = win[4]; win[2] = win[5];
        win[3] = top;    win[4] = mid;    win[5] = px;
        row_m2[c] = mid;
        row_m1[c] = px;
        if (c + 1 >= w) begin
            cur_col = 0;
            cur_row = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            cur_col = c + 1;
        end
    endtask

    task automatic restart_frame();
        cur_row = 0;
        cur_col = 0;
        foreach (win[i]) win[i] = '0;
    endtask

    always @(posedge i_clk) begin
        t_edge_res e;
        if (!i_rst_n) begin
            geo_w = 9'd256;
            geo_h = 13'd256;
            kmode = K_SOBEL;
            foreach (row_m2[i]) row_m2[i] = '0;
            foreach (row_m1[i]) row_m1[i] = '0;
            restart_frame();
            exp_q.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WIDTH: begin
                        geo_w = i_cfg_data[8:0];
                        restart_frame();
                    end
                    CFG_HEIGHT: begin
                        geo_h = i_cfg_data[12:0];
                        restart_frame();
                    end
                    CFG_KERNEL: kmode = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_valid && !i_in_stall) predict_pixel(i_pixel);
            if (i_out_valid && !i_out_stall) begin
                if (exp_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected result row %0d col %0d mag %0d last %0b",
                                 i_out_row, i_out_col, i_magnitude, i_last);
                end else begin
                    e = exp_q.pop_front();
                    if (e.row !== i_out_row || e.col !== i_out_col ||
                        e.mag !== i_magnitude || e.last !== i_last) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch: exp row %0d col %0d mag %0d last %0b, %s",
                                     e.row, e.col, e.mag, e.last,
                                     $sformatf("got row %0d col %0d mag %0d last %0b",
                                               i_out_row, i_out_col, i_magnitude, i_last));
                    end
                end
            end
        end
    end

endmodule

>>> test/tb_top.sv
//------------------------------------------------------------------------------
// tb_top
// Drives raster pixel frames of varied geometry and kernel into the edge
// magnitude unit under several idle and stall mixes; the checker predicts
// and compares the results, this module gives the verdict.
//------------------------------------------------------------------------------
module tb_top;
    import gem3_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CIDX_W-1:0] i_cfg_idx = CFG_WIDTH;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              i_valid = 1'b0;
    logic [PIX_W-1:0]  i_pixel = '0;
    logic              i_stall = 1'b0;
    logic              o_stall, o_valid, o_last;
    logic [ROW_W-1:0]  o_out_row;
    logic [COL_W-1:0]  o_out_col;
    logic [PIX_W-1:0]  o_magnitude;
    int                errors, pending;
    int                idle_pct = 0, stall_pct = 0;
    int                cycles = 0;

    always #4 i_clk = ~i_clk;

    gradient_edge_magnitude_3x3_unit i_dut (.*);

    gem3_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_valid(i_valid), .i_in_stall(o_stall),
        .i_pixel(i_pixel), .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_out_row(o_out_row), .i_out_col(o_out_col), .i_magnitude(o_magnitude),
        .i_last(o_last), .o_errors(errors), .o_pending(pending)
    );

    always @(negedge i_clk) i_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 46; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 46; end
            default: begin idle_pct = 23; stall_pct = 23; end
        endcase
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] px);
        while ($urandom_range(99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_pixel = px;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        @(negedge i_clk);
    endtask

    // hold until all results are in, then let pixels without results retire
    task automatic drain();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    initial begin
        int w, h, n, sent, phase;
        logic [CFG_W-1:0] wv, hv;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset geometry, first row only
        for (int i = 0; i < 6; i++) send_pixel(i[0] ? 8'hFF : 8'h00);
        drain();

        // smallest frame with extreme pixels, Roberts, Prewitt, mode three
        write_reg(CFG_WIDTH, 3);
        write_reg(CFG_HEIGHT, 3);
        for (int k = 0; k < 3; k++) begin
            write_reg(CFG_KERNEL, (k == 2) ? 3 : k);
            for (int i = 0; i < 9; i++) send_pixel(((i + k) % 2) ? 8'hFF : 8'h00);
            drain();
        end

        // clamped width and height
        write_reg(CFG_KERNEL, K_SOBEL);
        write_reg(CFG_WIDTH, 511);
        write_reg(CFG_HEIGHT, 8191);
        for (int i = 0; i < 20; i++) send_pixel($urandom_range(255));
        drain();

        sent = 0;
        phase = 0;
        while (sent < 110) begin
            set_idling(phase);
            case ($urandom_range(9))
                0: wv = $urandom_range(2);
                1: wv = $urandom_range(511, 257);
                default: wv = $urandom_range(8, 3);
            endcase
            case ($urandom_range(9))
                0: hv = $urandom_range(2);
                1: hv = $urandom_range(8191, 4097);
                default: hv = $urandom_range(5, 3);
            endcase
            w = (wv < 3) ? 3 : (wv > 256) ? 256 : wv;
            h = (hv < 3) ? 3 : (hv > 5) ? 5 : hv;
            write_reg(CFG_KERNEL, $urandom_range(3));
            write_reg(CFG_WIDTH, wv);
            write_reg(CFG_HEIGHT, hv);
            n = (w > 16) ? 20 : w * h + (($urandom_range(3) == 0) ? $urandom_range(2 * w) : 0);
            for (int i = 0; i < n; i++) send_pixel($urandom_range(255));
            sent += n;
            drain();
            phase++;
        end

        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
